/* hw/rtl/bis_pkg.sv */
// Shared types, constants and codes for the bicubic image scaler.
// No dependencies; every other file imports this package.
package bis_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_CHANNELS   = 3;

  localparam int IDX_W  = 10;
  localparam int AW_MAX = 20;
  localparam int POS_W  = 18;
  localparam int T_BITS = 12;
  localparam int P_W    = 20;
  localparam int C_W    = 24;
  localparam int ACC_W  = 64;
  localparam int RES_SHIFT = 3 * T_BITS + 1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_X_STEP     = 2'd2;
  localparam logic [1:0] REG_Y_STEP     = 2'd3;

  localparam logic [1:0] HS_COEF = 2'd0;
  localparam logic [1:0] HS_MUL1 = 2'd1;
  localparam logic [1:0] HS_MUL2 = 2'd2;
  localparam logic [1:0] HS_MUL3 = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [23:0]       data;
    logic [AW_MAX-1:0] addr;
    logic [POS_W-1:0]  ix0;
    logic [T_BITS-1:0] tx;
    logic [POS_W-1:0]  iy0;
    logic [T_BITS-1:0] ty;
    logic [IDX_W-1:0]  xlast;
    logic [IDX_W-1:0]  ylast;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic [1:0] step;
  } herm_ctl_t;

endpackage

/* hw/rtl/bis_front.sv */
// Front end: accepts items, drops out-of-range loads, computes positions.
// Depends on bis_pkg; feeds bis_queue.
module bis_front #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      push,
  output logic                      full,
  input  logic                      kind,
  input  logic [9:0]                col,
  input  logic [9:0]                row,
  input  logic [7:0]                in_ch0,
  input  logic [7:0]                in_ch1,
  input  logic [7:0]                in_ch2,
  input  logic [7:0]                src_width,
  input  logic [7:0]                src_height,
  input  logic [23:0]               x_step,
  input  logic [23:0]               y_step,
  input  logic                      q_full,
  output logic                      q_push,
  output bis_pkg::cmd_t             q_data
);
  import bis_pkg::*;

  logic [33:0] px;
  logic [33:0] py;
  logic [10:0] wlim;
  logic [10:0] hlim;
  logic        in_range;

  always_comb begin
    if (src_width == 8'd0) begin
      wlim = 11'd1;
    end else if (11'(src_width) > 11'(MAX_WIDTH)) begin
      wlim = 11'(MAX_WIDTH);
    end else begin
      wlim = 11'(src_width);
    end
    if (src_height == 8'd0) begin
      hlim = 11'd1;
    end else if (11'(src_height) > 11'(MAX_HEIGHT)) begin
      hlim = 11'(MAX_HEIGHT);
    end else begin
      hlim = 11'(src_height);
    end
  end

  assign px = 34'(x_step) * 34'(col);
  assign py = 34'(y_step) * 34'(row);
  assign in_range = (11'(col) < 11'(MAX_WIDTH)) && (11'(row) < 11'(MAX_HEIGHT));

  assign full   = q_full;
  assign q_push = push && !q_full && ((kind == KIND_COMPUTE) || in_range);

  always_comb begin
    q_data.kind  = kind;
    q_data.col   = col;
    q_data.row   = row;
    q_data.data  = {in_ch2, in_ch1, in_ch0};
    q_data.addr  = AW_MAX'(AW_MAX'(row) * AW_MAX'(MAX_WIDTH) + AW_MAX'(col));
    q_data.ix0   = px[33:16];
    q_data.tx    = px[15:4];
    q_data.iy0   = py[33:16];
    q_data.ty    = py[15:4];
    q_data.xlast = 10'(wlim - 11'd1);
    q_data.ylast = 10'(hlim - 11'd1);
  end

endmodule

/* hw/rtl/bis_queue.sv */
// Four-entry command queue between front and back end.
// Depends on bis_pkg for the command type.
module bis_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  bis_pkg::cmd_t wdata,
  output logic          q_full,
  input  logic          rd,
  output logic          q_empty,
  output bis_pkg::cmd_t rdata
);
  import bis_pkg::*;

  cmd_t       slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign q_full  = (count == 3'd4);
  assign q_empty = (count == 3'd0);
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (wr) begin
        wptr <= wptr + 2'd1;
      end
      if (rd) begin
        rptr <= rptr + 2'd1;
      end
      if (wr && !rd) begin
        count <= count + 3'd1;
      end else if (rd && !wr) begin
        count <= count - 3'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rd |-> !q_empty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) wr |-> !q_full)
    else $error("queue write while full");
  assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + 3'd1))
    else $error("queue count lost a write");

endmodule

/* hw/rtl/bis_hermite.sv */
// One channel lane of the Catmull-Rom pass, evaluated by Horner steps.
// Depends on bis_pkg; sequenced by bis_back.
module bis_hermite (
  input  logic                          clk,
  input  bis_pkg::herm_ctl_t            ctl,
  input  logic signed [bis_pkg::P_W-1:0] p0,
  input  logic signed [bis_pkg::P_W-1:0] p1,
  input  logic signed [bis_pkg::P_W-1:0] p2,
  input  logic signed [bis_pkg::P_W-1:0] p3,
  input  logic [bis_pkg::T_BITS-1:0]    t,
  output logic signed [bis_pkg::P_W-1:0] res
);
  import bis_pkg::*;

  logic signed [C_W-1:0]     e0, e1, e2, e3;
  logic signed [C_W-1:0]     a2, b2, c2, pb;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W+12:0]  prod;
  logic signed [T_BITS:0]    ts;
  logic signed [ACC_W-1:0]   addend;

  assign e0 = C_W'(p0);
  assign e1 = C_W'(p1);
  assign e2 = C_W'(p2);
  assign e3 = C_W'(p3);
  assign ts = $signed({1'b0, t});
  assign prod = acc * ts;

  always_comb begin
    case (ctl.step)
      HS_MUL1: addend = ACC_W'(b2) <<< T_BITS;
      HS_MUL2: addend = ACC_W'(c2) <<< (2 * T_BITS);
      HS_MUL3: addend = ACC_W'(pb) <<< RES_SHIFT;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.step)
        HS_COEF: begin
          a2  <= (e1 <<< 1) + e1 + e3 - e0 - (e2 <<< 1) - e2;
          b2  <= (e0 <<< 1) + (e2 <<< 2) - (e1 <<< 2) - e1 - e3;
          c2  <= e2 - e0;
          pb  <= e1;
          acc <= ACC_W'(a2);
        end
        HS_MUL1: acc <= ACC_W'(a2) * ACC_W'(ts) + addend;
        default: acc <= prod[ACC_W-1:0] + addend;
      endcase
    end
  end

  assign res = acc[RES_SHIFT +: P_W];

endmodule

/* hw/rtl/bis_back.sv */
// Back end: frame store, neighbourhood gather, row and column passes, result register.
// Depends on bis_pkg and bis_hermite; drains bis_queue.
module bis_back #(
  parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = bis_pkg::DEF_CHANNELS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  bis_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [9:0]    out_col,
  output logic [9:0]    out_row,
  output logic [7:0]    out_ch0,
  output logic [7:0]    out_ch1,
  output logic [7:0]    out_ch2
);
  import bis_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = CHANNELS * 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_COL  = 2'd3;

  logic [DW-1:0]          mem [DEPTH];
  logic [DW-1:0]          rdata;
  logic [DW-1:0]          pix [16];
  logic signed [P_W-1:0]  colv [CHANNELS][4];
  logic signed [P_W-1:0]  hres [CHANNELS];
  logic [7:0]             och [3];
  logic [7:0]             chv [3];

  logic [1:0]        st;
  cmd_t              cmd;
  logic [4:0]        cnt;
  logic [1:0]        m;
  logic [2:0]        step;
  logic              out_valid;
  herm_ctl_t         hctl;
  logic [AW-1:0]     raddr;
  logic [IDX_W-1:0]  xs;
  logic [IDX_W-1:0]  ys;
  logic signed [19:0] sx;
  logic signed [19:0] sy;
  logic [3:0]        pix_idx;
  logic              out_load;

  assign q_pop = (st == ST_IDLE) && !q_empty;
  assign empty = !out_valid;
  assign pix_idx = 4'(cnt - 5'd1);
  assign out_load = (st == ST_COL) && (step == 3'd4) && (!out_valid || pop);

  always_comb begin
    sx = $signed(20'({2'b0, cmd.ix0})) + $signed(20'(cnt[1:0])) - 20'sd1;
    sy = $signed(20'({2'b0, cmd.iy0})) + $signed(20'(cnt[3:2])) - 20'sd1;
    if (sx < 0) begin
      xs = '0;
    end else if (sx > $signed(20'(cmd.xlast))) begin
      xs = cmd.xlast;
    end else begin
      xs = sx[IDX_W-1:0];
    end
    if (sy < 0) begin
      ys = '0;
    end else if (sy > $signed(20'(cmd.ylast))) begin
      ys = cmd.ylast;
    end else begin
      ys = sy[IDX_W-1:0];
    end
    raddr = AW'(AW_MAX'(ys) * AW_MAX'(MAX_WIDTH) + AW_MAX'(xs));
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.kind == KIND_LOAD)) begin
      mem[q_data.addr[AW-1:0]] <= q_data.data[DW-1:0];
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    hctl.en   = ((st == ST_ROW) || (st == ST_COL)) && (step != 3'd4);
    hctl.step = step[1:0];
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    if (k < CHANNELS) begin : g_on
      logic signed [P_W-1:0] pv [4];
      logic signed [P_W-1:0] v;
      for (genvar n = 0; n < 4; n++) begin : g_tap
        assign pv[n] = (st == ST_COL) ? colv[k][n] :
                       $signed(P_W'({pix[{m, 2'(n)}][8*k +: 8], 8'd0}));
      end
      bis_hermite u_herm (
        .clk (clk),
        .ctl (hctl),
        .p0  (pv[0]),
        .p1  (pv[1]),
        .p2  (pv[2]),
        .p3  (pv[3]),
        .t   ((st == ST_COL) ? cmd.ty : cmd.tx),
        .res (hres[k])
      );
      assign v = hres[k] >>> 8;
      always_comb begin
        if (v < 0) begin
          chv[k] = 8'd0;
        end else if (v > $signed(P_W'(255))) begin
          chv[k] = 8'd255;
        end else begin
          chv[k] = v[7:0];
        end
      end
      always_ff @(posedge clk) begin
        if ((st == ST_ROW) && (step == 3'd4)) begin
          colv[k][m] <= hres[k];
        end
      end
    end else begin : g_off
      assign chv[k] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if ((st == ST_READ) && (cnt != 5'd0)) begin
      pix[pix_idx] <= rdata;
    end
    if (out_load) begin
      out_col <= cmd.col;
      out_row <= cmd.row;
      och[0]  <= chv[0];
      och[1]  <= chv[1];
      och[2]  <= chv[2];
    end
  end

  assign out_ch0 = och[0];
  assign out_ch1 = och[1];
  assign out_ch2 = och[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      cnt       <= '0;
      m         <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (q_pop && (q_data.kind == KIND_COMPUTE)) begin
            cnt <= '0;
            st  <= ST_READ;
          end
        end
        ST_READ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            m    <= '0;
            step <= '0;
            st   <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (step == 3'd4) begin
            step <= '0;
            m    <= m + 2'd1;
            if (m == 2'd3) begin
              st <= ST_COL;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_COL: begin
          if (step != 3'd4) begin
            step <= step + 3'd1;
          end else if (out_load) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (st == ST_COL && step == 3'd4 && out_valid && !pop) |=> (st == ST_COL))
    else $error("result dropped while output held");
  assert property (@(posedge clk) disable iff (rst)
    hctl.en |-> (st == ST_ROW || st == ST_COL))
    else $error("lane stepped outside a pass");
  assert property (@(posedge clk) disable iff (rst)
    (st == ST_READ) |-> (cnt <= 5'd16))
    else $error("gather counter overrun");
  assert property (@(posedge clk) disable iff (rst)
    (st == ST_ROW && step == 3'd4 && m == 2'd3) |=> (st == ST_COL && step == 3'd0))
    else $error("column pass did not follow row passes");

endmodule

/* hw/rtl/bicubic_image_scaler_unit.sv */
// Bicubic scaler top level: config registers, front end, queue, back end.
// Depends on bis_pkg, bis_front, bis_queue, bis_back, bis_hermite.
// Load item: one store write at the back end; one load per cycle while the back end is idle.
// Compute item: the back end takes no new item until its result is registered; store reads
// gather 16 neighbours, then five passes (four row, one column), one Horner unit per channel.
// Reset (rst, synchronous): queue and result register empty, registers to defaults.
module bicubic_image_scaler_unit
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int CHANNELS   = DEF_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [9:0]  col,
  input  logic [9:0]  row,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [23:0] wr_data
);

  logic [7:0]  src_width;
  logic [7:0]  src_height;
  logic [23:0] x_step;
  logic [23:0] y_step;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  cmd_t        q_in;
  cmd_t        q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 8'd128;
      src_height <= 8'd128;
      x_step     <= 24'd32768;
      y_step     <= 24'd32768;
    end else if (wr_en) begin
      case (wr_index)
        REG_SRC_WIDTH:  src_width  <= wr_data[7:0];
        REG_SRC_HEIGHT: src_height <= wr_data[7:0];
        REG_X_STEP:     x_step     <= wr_data;
        REG_Y_STEP:     y_step     <= wr_data;
        default: ;
      endcase
    end
  end

  bis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .push       (push),
    .full       (full),
    .kind       (kind),
    .col        (col),
    .row        (row),
    .in_ch0     (in_ch0),
    .in_ch1     (in_ch1),
    .in_ch2     (in_ch2),
    .src_width  (src_width),
    .src_height (src_height),
    .x_step     (x_step),
    .y_step     (y_step),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  bis_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rdata   (q_out)
  );

  bis_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_col (out_col),
    .out_row (out_row),
    .out_ch0 (out_ch0),
    .out_ch1 (out_ch1),
    .out_ch2 (out_ch2)
  );

endmodule
